### rtl/b64c_pkg.sv
// Shared types and constants for the base64 stream codec.
package b64c_pkg;

  // Pad character of the base64 alphabet
  localparam logic [7:0] PAD_CHAR = 8'h3D;

  // Codec modes
  typedef enum logic {
    MODE_ENCODE = 1'b0,
    MODE_DECODE = 1'b1
  } mode_t;

  // Input request payload
  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  // Output request payload
  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } out_item_t;

  // One gathered group, handed from front to back.
  // num: encode - bytes held (1..3); decode - bytes to emit (1..3).
  typedef struct packed {
    mode_t       mode;
    logic [23:0] bits;
    logic [1:0]  num;
    logic        last;
  } grp_rec_t;

endpackage

### rtl/b64c_front.sv
// Front end: accepts input requests, gathers groups and queues finished ones.
module b64c_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic                cfg_wdata,
  input  logic                in_valid,
  output logic                in_ready,
  input  b64c_pkg::in_item_t  in_data,
  input  logic                q_full,
  output logic                q_push,
  output b64c_pkg::grp_rec_t  q_rec
);

  // Map an alphabet character to its 6-bit value; unknown and pad map to zero
  function automatic logic [5:0] char_value(input logic [7:0] c);
    logic [7:0] v;
    begin
      v = 8'd0;
      if (c >= 8'h41 && c <= 8'h5A) v = c - 8'h41;
      else if (c >= 8'h61 && c <= 8'h7A) v = c - 8'h61 + 8'd26;
      else if (c >= 8'h30 && c <= 8'h39) v = c - 8'h30 + 8'd52;
      else if (c == 8'h2B) v = 8'd62;
      else if (c == 8'h2F) v = 8'd63;
      return v[5:0];
    end
  endfunction

  b64c_pkg::mode_t mode_r, mode_nxt;
  logic [23:0]     bits_r, bits_nxt;
  logic [1:0]      gc_r, gc_nxt;
  logic            pad_r, pad_nxt;

  logic            accept;
  logic [23:0]     bits_new;
  logic [5:0]      val;
  logic            is_pad;
  logic            pad_new;
  logic [1:0]      trim;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign val      = char_value(in_data.in_byte);
  assign is_pad   = (in_data.in_byte == b64c_pkg::PAD_CHAR);

  // Merge the incoming item into the group
  always_comb begin
    bits_new = bits_r;
    if (mode_r == b64c_pkg::MODE_ENCODE) begin
      case (gc_r)
        2'd0:    bits_new[23:16] = in_data.in_byte;
        2'd1:    bits_new[15:8]  = in_data.in_byte;
        default: bits_new[7:0]   = in_data.in_byte;
      endcase
    end else begin
      case (gc_r)
        2'd0:    bits_new[23:18] = val;
        2'd1:    bits_new[17:12] = val;
        2'd2:    bits_new[11:6]  = val;
        default: bits_new[5:0]   = val;
      endcase
    end
  end

  assign pad_new = pad_r || (gc_r == 2'd2 && is_pad);
  // final group trims one byte per pad in the third and fourth positions
  assign trim    = in_data.in_last ? ({1'b0, pad_r} + {1'b0, is_pad}) : 2'd0;

  // Group state update and push decision
  always_comb begin
    mode_nxt   = mode_r;
    bits_nxt   = bits_r;
    gc_nxt     = gc_r;
    pad_nxt    = pad_r;
    q_push     = 1'b0;
    q_rec.mode = mode_r;
    q_rec.bits = bits_new;
    q_rec.num  = gc_r + 2'd1;
    q_rec.last = in_data.in_last;
    if (cfg_we) begin
      mode_nxt = b64c_pkg::mode_t'(cfg_wdata);
      bits_nxt = 24'd0;
      gc_nxt   = 2'd0;
      pad_nxt  = 1'b0;
    end else if (accept) begin
      if (mode_r == b64c_pkg::MODE_ENCODE) begin
        if (gc_r == 2'd2 || in_data.in_last) begin
          q_push   = 1'b1;
          bits_nxt = 24'd0;
          gc_nxt   = 2'd0;
        end else begin
          bits_nxt = bits_new;
          gc_nxt   = gc_r + 2'd1;
        end
      end else begin
        if (gc_r == 2'd3) begin
          q_push    = 1'b1;
          q_rec.num = 2'd3 - trim;
          bits_nxt  = 24'd0;
          gc_nxt    = 2'd0;
          pad_nxt   = 1'b0;
        end else if (in_data.in_last) begin
          // incomplete final group is dropped
          bits_nxt = 24'd0;
          gc_nxt   = 2'd0;
          pad_nxt  = 1'b0;
        end else begin
          bits_nxt = bits_new;
          gc_nxt   = gc_r + 2'd1;
          pad_nxt  = pad_new;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= b64c_pkg::MODE_ENCODE;
      bits_r <= 24'd0;
      gc_r   <= 2'd0;
      pad_r  <= 1'b0;
    end else begin
      mode_r <= mode_nxt;
      bits_r <= bits_nxt;
      gc_r   <= gc_nxt;
      pad_r  <= pad_nxt;
    end
  end

endmodule

### rtl/b64c_fifo.sv
// Short queue of gathered groups between front and back.
module b64c_fifo #(
  parameter int DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  b64c_pkg::grp_rec_t push_rec,
  output logic               full,
  input  logic               pop,
  output logic               head_valid,
  output b64c_pkg::grp_rec_t head_rec
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  b64c_pkg::grp_rec_t mem_r [DEPTH];
  logic [AW-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]      count_r, count_nxt;

  assign full       = (count_r == CW'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_rec   = mem_r[rd_ptr_r];

  // Pointer and occupancy update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    if (pop)  rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    if (push && !pop)      count_nxt = count_r + CW'(1);
    else if (pop && !push) count_nxt = count_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage, no reset
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_rec;
  end

`ifndef SYNTH
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
    else $error("group pushed into full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n) !(pop && !head_valid))
    else $error("group popped from empty queue");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n) count_r <= CW'(DEPTH))
    else $error("queue occupancy out of range");
  a_reset_empty: assert property (@(posedge clk) $past(!rst_n) |-> count_r == '0)
    else $error("queue not empty after reset");
`endif

endmodule

### rtl/b64c_back.sv
// Back end: expands queued groups into output requests, one byte per cycle while out_ready holds.
module b64c_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                head_valid,
  input  b64c_pkg::grp_rec_t  head_rec,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output b64c_pkg::out_item_t out_data
);

  // Map a 6-bit value to its alphabet character
  function automatic logic [7:0] alph_char(input logic [5:0] idx);
    logic [7:0] i;
    begin
      i = {2'b00, idx};
      if (i < 8'd26)      return 8'h41 + i;
      else if (i < 8'd52) return 8'h61 + i - 8'd26;
      else if (i < 8'd62) return 8'h30 + i - 8'd52;
      else if (i == 8'd62) return 8'h2B;
      else return 8'h2F;
    end
  endfunction

  logic [1:0]          k_r, k_nxt;
  logic                out_valid_r, out_valid_nxt;
  b64c_pkg::out_item_t out_data_r, out_data_nxt;

  logic [1:0]          last_k;
  logic                is_final;
  logic                load;
  logic [5:0]          sextet;
  logic [7:0]          dec_byte;
  logic [7:0]          cur_byte;

  assign last_k   = (head_rec.mode == b64c_pkg::MODE_DECODE) ? head_rec.num - 2'd1 : 2'd3;
  assign is_final = (k_r == last_k);
  assign load     = !out_valid_r || out_ready;
  assign pop      = head_valid && load && is_final;

  // Select the field of the group for position k
  always_comb begin
    case (k_r)
      2'd0:    sextet = head_rec.bits[23:18];
      2'd1:    sextet = head_rec.bits[17:12];
      2'd2:    sextet = head_rec.bits[11:6];
      default: sextet = head_rec.bits[5:0];
    endcase
    case (k_r)
      2'd0:    dec_byte = head_rec.bits[23:16];
      2'd1:    dec_byte = head_rec.bits[15:8];
      default: dec_byte = head_rec.bits[7:0];
    endcase
  end

  // Encode pads the tail of a short group
  always_comb begin
    if (head_rec.mode == b64c_pkg::MODE_DECODE) begin
      cur_byte = dec_byte;
    end else if ((k_r == 2'd2 && head_rec.num < 2'd2) ||
                 (k_r == 2'd3 && head_rec.num < 2'd3)) begin
      cur_byte = b64c_pkg::PAD_CHAR;
    end else begin
      cur_byte = alph_char(sextet);
    end
  end

  // Output register and position counter
  always_comb begin
    k_nxt         = k_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (load) begin
      out_valid_nxt = head_valid;
      if (head_valid) begin
        out_data_nxt.out_byte = cur_byte;
        out_data_nxt.out_last = head_rec.last && is_final;
        k_nxt                 = is_final ? 2'd0 : k_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r         <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTH
  a_k_idle_zero: assert property (@(posedge clk) disable iff (!rst_n) !head_valid |-> k_r == 2'd0)
    else $error("position counter moved without a queued group");
  a_k_bound: assert property (@(posedge clk) disable iff (!rst_n) head_valid |-> k_r <= last_k)
    else $error("position counter past end of group");
  a_last_on_pop: assert property (@(posedge clk) disable iff (!rst_n)
      (load && head_valid && head_rec.last && !is_final) |=> !out_data_r.out_last)
    else $error("last flag set before end of group");
`endif

endmodule

### rtl/base64_stream_codec.sv
// Top level of the base64 stream codec: front end, group queue, back end.
// A completing input request enters the group queue, then its first result is
// registered in the back end. Throughput: one input request per cycle while the
// queue has room; one output per cycle while out_ready holds, set by the back end's
// single output register; decode takes one input per cycle, encode 3 per 4 outputs.
// Reset (rst_n, synchronous): mode encode, group and queue empty, no output.
module base64_stream_codec #(
  parameter int FIFO_DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic                cfg_wdata,
  input  logic                in_valid,
  output logic                in_ready,
  input  b64c_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output b64c_pkg::out_item_t out_data
);

  logic               q_full;
  logic               q_push;
  b64c_pkg::grp_rec_t q_rec;
  logic               q_pop;
  logic               q_head_valid;
  b64c_pkg::grp_rec_t q_head;

  b64c_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_rec     (q_rec)
  );

  b64c_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_rec   (q_rec),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_rec   (q_head)
  );

  b64c_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_head_valid),
    .head_rec   (q_head),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

### tb/base64_stream_codec_tb.sv
// Self-checking testbench for the base64 stream codec: directed and random messages.
module base64_stream_codec_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_WAIT = 8;
  localparam int PRINT_MAX  = 20;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                cfg_we    = 1'b0;
  logic                cfg_wdata = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  b64c_pkg::in_item_t  in_data   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  b64c_pkg::out_item_t out_data;

  // pending input requests and expected coded results
  b64c_pkg::in_item_t  feed_q[$];
  b64c_pkg::out_item_t coded_q[$];
  b64c_pkg::out_item_t exp_r;

  // predictor state
  b64c_pkg::mode_t cur_mode = b64c_pkg::MODE_ENCODE;
  logic [23:0]     grp_bits = '0;
  logic [1:0]      grp_cnt  = '0;
  logic            grp_pad  = 1'b0;

  bit idling       = 1'b1;
  int in_gap       = 0;
  int out_stall    = 0;
  int quiet_cycles = 0;
  int n_queued     = 0;
  int n_in         = 0;
  int n_out        = 0;
  int n_cfg        = 0;
  int n_err        = 0;

  base64_stream_codec u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #4 clk = ~clk;

  // 6-bit value to alphabet character
  function automatic logic [7:0] b64_char(logic [5:0] idx);
    if (idx < 6'd26) return "A" + 8'(idx);
    if (idx < 6'd52) return "a" + 8'(idx - 6'd26);
    if (idx < 6'd62) return "0" + 8'(idx - 6'd52);
    if (idx == 6'd62) return "+";
    return "/";
  endfunction

  // alphabet character to 6-bit value; pad and unknown chars read as zero
  function automatic logic [5:0] b64_value(logic [7:0] c);
    if (c >= "A" && c <= "Z") return 6'(c - "A");
    if (c >= "a" && c <= "z") return 6'(c - "a" + 8'd26);
    if (c >= "0" && c <= "9") return 6'(c - "0" + 8'd52);
    if (c == "+") return 6'd62;
    if (c == "/") return 6'd63;
    return 6'd0;
  endfunction

  task automatic clear_group();
    grp_bits = '0;
    grp_cnt  = '0;
    grp_pad  = 1'b0;
  endtask

  task automatic expect_out(logic [7:0] b, logic l);
    b64c_pkg::out_item_t r;
    r.out_byte = b;
    r.out_last = l;
    coded_q.push_back(r);
  endtask

  // advance the predicted codec by one accepted request
  task automatic codec_step(b64c_pkg::in_item_t it);
    int cnt;
    int nout;
    cnt = int'(grp_cnt);
    if (cur_mode == b64c_pkg::MODE_ENCODE) begin
      grp_bits = grp_bits | (24'(it.in_byte) << (16 - 8 * cnt));
      if (cnt == 2 || it.in_last) begin
        expect_out(b64_char(grp_bits[23:18]), 1'b0);
        expect_out(b64_char(grp_bits[17:12]), 1'b0);
        expect_out(cnt >= 1 ? b64_char(grp_bits[11:6]) : b64c_pkg::PAD_CHAR, 1'b0);
        expect_out(cnt >= 2 ? b64_char(grp_bits[5:0]) : b64c_pkg::PAD_CHAR, it.in_last);
        clear_group();
      end else begin
        grp_cnt = grp_cnt + 2'd1;
      end
    end else begin
      grp_bits = grp_bits | (24'(b64_value(it.in_byte)) << (18 - 6 * cnt));
      if (cnt == 2 && it.in_byte == b64c_pkg::PAD_CHAR) grp_pad = 1'b1;
      if (cnt == 3) begin
        nout = 3;
        // pads only trim in the final group
        if (it.in_last)
          nout = 3 - int'(grp_pad) - ((it.in_byte == b64c_pkg::PAD_CHAR) ? 1 : 0);
        for (int k = 0; k < nout; k++) begin
          expect_out(8'(grp_bits >> (16 - 8 * k)), it.in_last && k == nout - 1);
        end
        clear_group();
      end else if (it.in_last) begin
        // short final group is dropped
        clear_group();
      end else begin
        grp_cnt = grp_cnt + 2'd1;
      end
    end
  endtask

  task automatic report_mismatch(string msg);
    n_err++;
    if (n_err <= PRINT_MAX) $display("%0t mismatch: %s", $time, msg);
  endtask

  task automatic push_byte(logic [7:0] b, logic l);
    b64c_pkg::in_item_t it;
    it.in_byte = b;
    it.in_last = l;
    feed_q.push_back(it);
    n_queued++;
  endtask

  task automatic push_text(string s, bit l);
    for (int i = 0; i < s.len(); i++) begin
      push_byte(s[i], l && i == s.len() - 1);
    end
  endtask

  // mode write also drops any partial group
  task automatic write_mode(b64c_pkg::mode_t m);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    cur_mode = m;
    clear_group();
    @(posedge clk);
    cfg_we <= 1'b0;
    n_cfg++;
  endtask

  task automatic wait_idle();
    while (feed_q.size() != 0 || in_valid || coded_q.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // random byte message, mostly short
  task automatic push_enc_msg();
    int len;
    len = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
    for (int i = 0; i < len; i++) begin
      push_byte(8'($urandom_range(0, 255)), i == len - 1);
    end
  endtask

  // well-formed base64 text most of the time, otherwise corrupted or cut short
  task automatic push_dec_msg();
    logic [7:0]  txt[$];
    logic [23:0] w;
    int          nbytes;
    int          kind;
    nbytes = $urandom_range(1, 7);
    for (int i = 0; i < nbytes; i += 3) begin
      w = 24'($urandom);
      txt.push_back(b64_char(w[23:18]));
      txt.push_back(b64_char(w[17:12]));
      txt.push_back(nbytes - i > 1 ? b64_char(w[11:6]) : b64c_pkg::PAD_CHAR);
      txt.push_back(nbytes - i > 2 ? b64_char(w[5:0]) : b64c_pkg::PAD_CHAR);
    end
    kind = $urandom_range(0, 9);
    if (kind == 7) begin
      txt[$urandom_range(0, txt.size() - 1)] = b64c_pkg::PAD_CHAR;
    end else if (kind == 8) begin
      txt[$urandom_range(0, txt.size() - 1)] = 8'($urandom_range(0, 255));
    end else if (kind == 9) begin
      repeat ($urandom_range(1, 3)) txt.pop_back();
    end
    for (int i = 0; i < txt.size(); i++) begin
      push_byte(txt[i], i == txt.size() - 1);
    end
  endtask

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap   <= 0;
    end else begin
      if (in_valid && in_ready) begin
        codec_step(in_data);
        n_in++;
      end
      if (!in_valid || in_ready) begin
        if (in_gap > 0) begin
          in_valid <= 1'b0;
          in_gap   <= in_gap - 1;
        end else if (idling && $urandom_range(0, 5) == 0) begin
          in_valid <= 1'b0;
          in_gap   <= $urandom_range(0, 10);
        end else if (feed_q.size() != 0) begin
          in_valid <= 1'b1;
          in_data  <= feed_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and output stall
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_stall <= 0;
    end else begin
      if (out_valid && out_ready) begin
        n_out++;
        if (coded_q.size() == 0) begin
          report_mismatch($sformatf("result %02h last %0b with none expected",
                                    out_data.out_byte, out_data.out_last));
        end else begin
          exp_r = coded_q.pop_front();
          if (out_data.out_byte !== exp_r.out_byte)
            report_mismatch($sformatf("out_byte %02h, expected %02h",
                                      out_data.out_byte, exp_r.out_byte));
          if (out_data.out_last !== exp_r.out_last)
            report_mismatch($sformatf("out_last %0b, expected %0b",
                                      out_data.out_last, exp_r.out_last));
        end
      end
      if (out_stall > 0) begin
        out_ready <= 1'b0;
        out_stall <= out_stall - 1;
      end else if (idling && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        out_stall <= $urandom_range(0, 10);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog: cycles with no request moving on either side
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < IDLE_LIMIT) @(posedge clk);
    $display("[base64_stream_codec] ERROR");
    $finish;
  end

  initial begin
    int start;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // encode edge cases from reset mode
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b1);
    push_byte(8'hFF, 1'b1);
    push_byte(8'hFB, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hBF, 1'b1);
    push_byte(8'h41, 1'b0);  // partial group, dropped by the mode write
    wait_idle();

    // decode edge cases: trimming, mid-message pads, unknown chars, short tail
    write_mode(b64c_pkg::MODE_DECODE);
    push_text("TQ==", 1'b1);
    push_text("TWE=", 1'b1);
    push_text("AB=C", 1'b1);
    push_text("AB==", 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_text("~/", 1'b1);
    push_text("QU", 1'b1);
    push_text("Q", 1'b0);
    wait_idle();

    // random messages with idling on both sides
    write_mode(b64c_pkg::MODE_ENCODE);
    start = n_queued;
    while (n_queued - start < 30) push_enc_msg();
    wait_idle();

    write_mode(b64c_pkg::MODE_DECODE);
    start = n_queued;
    while (n_queued - start < 35) push_dec_msg();
    wait_idle();
    write_mode(b64c_pkg::MODE_DECODE);

    // final stretch at full rate
    idling = 1'b0;
    write_mode(b64c_pkg::MODE_ENCODE);
    start = n_queued;
    while (n_queued - start < 20) push_enc_msg();
    wait_idle();

    write_mode(b64c_pkg::MODE_DECODE);
    start = n_queued;
    while (n_queued - start < 20) push_dec_msg();
    wait_idle();

    $display("run: %0d requests in, %0d results out, %0d mode writes, %0d mismatches",
             n_in, n_out, n_cfg, n_err);
    $display("run: directed pad and group cases, then random encode/decode traffic");
    if (n_err == 0) begin
      $display("[base64_stream_codec] OK");
    end else begin
      $display("[base64_stream_codec] ERROR");
    end
    $finish;
  end

endmodule
